@@ rtl/page_bitmap_allocator_core_macros.svh @@
// assertion helpers shared by the allocator rtl
`ifndef PAGE_BITMAP_ALLOCATOR_CORE_MACROS_SVH
`define PAGE_BITMAP_ALLOCATOR_CORE_MACROS_SVH

// condition that must hold at every edge out of reset
`define PBA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent in the same cycle
`define PBA_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent in the next cycle
`define PBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/pba_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pba_pkg;

  // fixed field widths
  localparam int PAGE_W = 15;
  localparam int FUNC_W = 2;

  // defaults for the top level parameters
  localparam int MAP_WORDS_DEF     = 1024;
  localparam int BITS_PER_WORD_DEF = 32;

  // operation codes (code 3 is a no-op)
  localparam logic [FUNC_W-1:0] FUNC_ALLOC     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE      = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_MARK_USED = 2'd2;

  // result status codes
  localparam logic STATUS_DONE      = 1'b0;
  localparam logic STATUS_NONE_FREE = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOCATE,
    ST_RANGE,
    ST_MODIFY,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_PAGE,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

@@ rtl/pba_bit_find.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pba_bit_find #(
  parameter int BPW = pba_pkg::BITS_PER_WORD_DEF,
  localparam int BIT_W = $clog2(BPW)
) (
  input  wire logic [BPW-1:0]   word,
  output logic                  any,
  output logic [BIT_W-1:0]      idx,
  output logic [BPW-1:0]        cleared
);
  import pba_pkg::*;

  logic [BPW-1:0] lowest;

  // isolate lowest set bit and drop it from the word
  assign lowest  = word & (~word + BPW'(1));
  assign cleared = word & (word - BPW'(1));
  assign any     = |word;

  // one-hot to binary, each output bit an or over its positions
  always_comb begin
    idx = '0;
    for (int j = 0; j < BPW; j++) begin
      if (lowest[j]) begin
        idx = idx | BIT_W'(j);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/page_bitmap_allocator_core.sv @@
// free and mark-used pass through the locate, range and modify states to the done
// state, skipping modify for a page beyond the map; allocate reads and checks one
// bitmap word per scan step, starting at the lowest word that may hold a free
// page; one memory read port, one operation at a time; the next input beat is
// taken while a result waits in the output register; reset: a clearing pass
// writes every word to all-used, during which no input beat is taken
`timescale 1ns / 1ps
`default_nettype none

`include "page_bitmap_allocator_core_macros.svh"

module page_bitmap_allocator_core #(
  parameter int MAP_WORDS     = pba_pkg::MAP_WORDS_DEF,
  parameter int BITS_PER_WORD = pba_pkg::BITS_PER_WORD_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [pba_pkg::FUNC_W-1:0]  in_func,
  input  wire logic [pba_pkg::PAGE_W-1:0]  in_page_number,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [pba_pkg::PAGE_W-1:0]       out_page_number_out,
  output logic                             out_status
);
  import pba_pkg::*;

  localparam int BPW    = BITS_PER_WORD;
  localparam int BIT_W  = $clog2(BPW);
  localparam int AW     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CNT_W  = $clog2(MAP_WORDS + 1);
  // page / BPW by reciprocal, exact for every PAGE_W-bit page
  localparam int SHIFT  = PAGE_W + BIT_W;
  localparam longint unsigned RECIP = ((64'd1 << SHIFT) + BPW - 1) / BPW;
  localparam int RECIP_W = SHIFT + 1;
  localparam int PROD_W  = PAGE_W + RECIP_W;
  localparam int BASE_W  = PAGE_W + BIT_W + 1;
  localparam int APW     = AW + BIT_W + 1;

  state_t state_r, state_nxt;

  logic [FUNC_W-1:0] func_r, func_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [PAGE_W-1:0] wq_r, wq_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic [CNT_W-1:0]  scan_r, scan_nxt;
  logic [CNT_W-1:0]  hint_r, hint_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [AW-1:0]     found_word_r, found_word_nxt;
  logic [PAGE_W-1:0] res_page_r, res_page_nxt;
  logic              res_status_r, res_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [PAGE_W-1:0] out_page_r, out_page_nxt;
  logic              out_status_r, out_status_nxt;

  logic [BPW-1:0]    mem [MAP_WORDS];
  logic [BPW-1:0]    rd_data_r;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [BPW-1:0]    mem_wd;
  logic [AW-1:0]     mem_ra;

  logic [PROD_W-1:0] quot_prod;
  logic [BASE_W-1:0] word_base;
  logic [BASE_W-1:0] bit_diff;
  logic [APW-1:0]    alloc_page;
  logic [BPW-1:0]    bit_mask;
  logic              wq_in_map;

  logic              find_any;
  logic [BIT_W-1:0]  find_idx;
  logic [BPW-1:0]    find_cleared;

  // lowest free bit of the word just read
  pba_bit_find #(
    .BPW (BPW)
  ) u_bit_find (
    .word    (rd_data_r),
    .any     (find_any),
    .idx     (find_idx),
    .cleared (find_cleared)
  );

  // address arithmetic, combinational from registered operands
  assign quot_prod  = PROD_W'(page_r) * PROD_W'(RECIP_W'(RECIP));
  assign word_base  = BASE_W'(wq_r) * BASE_W'(BPW);
  assign bit_diff   = BASE_W'(page_r) - word_base;
  assign alloc_page = APW'(found_word_r) * APW'(BPW) + APW'(bit_r);
  assign bit_mask   = BPW'(1) << bit_r;
  assign wq_in_map  = 32'(wq_r) < MAP_WORDS;

  assign in_stall            = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_page_number_out = out_page_r;
  assign out_status          = out_status_r;

  // bitmap store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      hint_r      <= CNT_W'(MAP_WORDS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      hint_r      <= hint_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    page_r       <= page_nxt;
    wq_r         <= wq_nxt;
    bit_r        <= bit_nxt;
    scan_r       <= scan_nxt;
    found_word_r <= found_word_nxt;
    res_page_r   <= res_page_nxt;
    res_status_r <= res_status_nxt;
    out_page_r   <= out_page_nxt;
    out_status_r <= out_status_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    page_nxt       = page_r;
    wq_nxt         = wq_r;
    bit_nxt        = bit_r;
    scan_nxt       = scan_r;
    hint_nxt       = hint_r;
    clr_nxt        = clr_r;
    found_word_nxt = found_word_r;
    res_page_nxt   = res_page_r;
    res_status_nxt = res_status_r;
    out_page_nxt   = out_page_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    mem_we         = 1'b0;
    mem_wa         = wq_r[AW-1:0];
    mem_wd         = '0;
    mem_ra         = wq_r[AW-1:0];

    unique case (state_r)
      // wipe the map to all-used after reset
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_wa   = clr_r;
        mem_wd   = '0;
        clr_nxt  = clr_r + AW'(1);
        hint_nxt = CNT_W'(MAP_WORDS);
        if (clr_r == AW'(MAP_WORDS - 1)) begin
          clr_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      // take an input beat
      ST_IDLE: begin
        if (in_valid) begin
          func_nxt       = in_func;
          page_nxt       = in_page_number;
          res_page_nxt   = in_page_number;
          res_status_nxt = STATUS_DONE;
          unique case (in_func)
            FUNC_ALLOC: begin
              if (hint_r == CNT_W'(MAP_WORDS)) begin
                res_page_nxt   = '0;
                res_status_nxt = STATUS_NONE_FREE;
                state_nxt      = ST_DONE;
              end else begin
                scan_nxt  = hint_r;
                state_nxt = ST_SCAN_RD;
              end
            end
            FUNC_FREE, FUNC_MARK_USED: begin
              state_nxt = ST_LOCATE;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      // word index of the page
      ST_LOCATE: begin
        wq_nxt    = quot_prod[SHIFT +: PAGE_W];
        state_nxt = ST_RANGE;
      end
      // bit within the word, read the word if it lies in the map
      ST_RANGE: begin
        bit_nxt = bit_diff[BIT_W-1:0];
        mem_ra  = wq_r[AW-1:0];
        if (wq_in_map) begin
          state_nxt = ST_MODIFY;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      // set or clear the bit and write the word back
      ST_MODIFY: begin
        mem_we = 1'b1;
        mem_wa = wq_r[AW-1:0];
        if (func_r == FUNC_FREE) begin
          mem_wd = rd_data_r | bit_mask;
          if (CNT_W'(wq_r[AW-1:0]) < hint_r) begin
            hint_nxt = CNT_W'(wq_r[AW-1:0]);
          end
        end else begin
          mem_wd = rd_data_r & ~bit_mask;
        end
        state_nxt = ST_DONE;
      end
      // scan: read the next word
      ST_SCAN_RD: begin
        mem_ra    = scan_r[AW-1:0];
        state_nxt = ST_SCAN_CHK;
      end
      // scan: take the lowest free bit or move on
      ST_SCAN_CHK: begin
        if (find_any) begin
          mem_we         = 1'b1;
          mem_wa         = scan_r[AW-1:0];
          mem_wd         = find_cleared;
          found_word_nxt = scan_r[AW-1:0];
          bit_nxt        = find_idx;
          hint_nxt       = scan_r;
          state_nxt      = ST_PAGE;
        end else if (scan_r == CNT_W'(MAP_WORDS - 1)) begin
          hint_nxt       = CNT_W'(MAP_WORDS);
          res_page_nxt   = '0;
          res_status_nxt = STATUS_NONE_FREE;
          state_nxt      = ST_DONE;
        end else begin
          scan_nxt  = scan_r + CNT_W'(1);
          state_nxt = ST_SCAN_RD;
        end
      end
      // page number of the allocated bit
      ST_PAGE: begin
        res_page_nxt = PAGE_W'(alloc_page);
        state_nxt    = ST_DONE;
      end
      // hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_page_nxt   = res_page_r;
          out_status_nxt = res_status_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // checks
  `PBA_ASSERT_ALWAYS(a_hint_range, hint_r <= CNT_W'(MAP_WORDS), "scan hint beyond map")
  `PBA_ASSERT_IMPLY(a_no_write_idle, state_r == ST_IDLE || state_r == ST_DONE, !mem_we, "write outside an operation")
  `PBA_ASSERT_IMPLY(a_fail_page_zero, out_valid_r && out_status_r == STATUS_NONE_FREE, out_page_r == '0, "failed allocate with nonzero page")
  `PBA_ASSERT_IMPLY(a_scan_ptr, state_r == ST_SCAN_RD || state_r == ST_SCAN_CHK, scan_r < CNT_W'(MAP_WORDS) && scan_r >= hint_r, "scan pointer out of range")
  `PBA_ASSERT_NEXT(a_clear_end, state_r == ST_CLEAR && clr_r == AW'(MAP_WORDS - 1), state_r == ST_IDLE, "clearing pass did not finish")

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import pba_pkg::*;

  localparam int MAP_DEPTH   = MAP_WORDS_DEF;
  localparam int WORD_BITS   = BITS_PER_WORD_DEF;
  localparam int PAGE_COUNT  = MAP_DEPTH * WORD_BITS;
  localparam int STUCK_LIMIT = 20000;
  localparam int TAIL_CYCLES = 64;
  localparam int REPORT_MAX  = 10;

  // the one func code the block treats as a no-op
  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

  // random phase flavours
  typedef enum int {
    PH_FILL,
    PH_MIXED,
    PH_DRAIN
  } phase_kind_t;

  typedef struct {
    logic [PAGE_W-1:0] page;
    logic              status;
  } grant_t;

  // shadow of the free map and the grants it implies
  class frame_map_tracker;
    bit [WORD_BITS-1:0] free_words [MAP_DEPTH];
    grant_t             pending_grants [$];
    int                 mismatches;

    function int pending();
      return pending_grants.size();
    endfunction

    function void flag(string what, int want, int got);
      if (mismatches < REPORT_MAX)
        $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
      mismatches++;
    endfunction

    // work out the grant for an accepted request beat
    function void note_request(logic [FUNC_W-1:0] f, logic [PAGE_W-1:0] p);
      grant_t g;
      int     w;
      int     b;
      int     i;
      int     j;
      bit     found;
      g.page   = p;
      g.status = STATUS_DONE;
      w        = int'(p) / WORD_BITS;
      b        = int'(p) % WORD_BITS;
      case (f)
        FUNC_ALLOC: begin
          // first fit: lowest nonzero word, then its lowest set bit
          found    = 1'b0;
          g.page   = '0;
          g.status = STATUS_NONE_FREE;
          for (i = 0; i < MAP_DEPTH && !found; i++) begin
            if (free_words[i] != '0) begin
              for (j = 0; j < WORD_BITS && !found; j++) begin
                if (free_words[i][j]) begin
                  free_words[i][j] = 1'b0;
                  g.page           = PAGE_W'(i * WORD_BITS + j);
                  g.status         = STATUS_DONE;
                  found            = 1'b1;
                end
              end
            end
          end
        end
        FUNC_FREE: begin
          if (w < MAP_DEPTH) free_words[w][b] = 1'b1;
        end
        FUNC_MARK_USED: begin
          if (w < MAP_DEPTH) free_words[w][b] = 1'b0;
        end
        default: ;
      endcase
      pending_grants.push_back(g);
    endfunction

    // compare a result beat with the oldest grant
    function void check_grant(logic [PAGE_W-1:0] p, logic s);
      grant_t g;
      if (pending_grants.size() == 0) begin
        flag("result beat with nothing outstanding, page", -1, int'(p));
      end else begin
        g = pending_grants.pop_front();
        if (g.page !== p) flag("page_number_out", int'(g.page), int'(p));
        if (g.status !== s) flag("status", int'(g.status), int'(s));
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [FUNC_W-1:0] in_func = FUNC_NOP;
  logic [PAGE_W-1:0] in_page_number = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [PAGE_W-1:0] out_page_number_out;
  logic              out_status;

  logic              quiet = 1'b1;
  int                stuck_cycles = 0;
  frame_map_tracker  tracker = new();

  page_bitmap_allocator_core DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_page_number      (in_page_number),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_page_number_out (out_page_number_out),
    .out_status          (out_status)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // present one request beat and hold it until taken
  task automatic send_request(input logic [FUNC_W-1:0] f, input logic [PAGE_W-1:0] p);
    int gap;
    in_valid       <= 1'b1;
    in_func        <= f;
    in_page_number <= p;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result side back-pressure
  initial begin
    int n;
    forever begin
      n = quiet ? 0 : pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // beat monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) tracker.note_request(in_func, in_page_number);
      if (out_valid && !out_stall) tracker.check_grant(out_page_number_out, out_status);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles = stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  initial begin
    int          ph;
    int          roll;
    int          win;
    int          alloc_th;
    int          free_th;
    int          mark_th;
    phase_kind_t kind;
    logic [FUNC_W-1:0] f;
    logic [PAGE_W-1:0] p;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty map, edge pages, repeats, no-op code, first fit order
    quiet = 1'b0;
    send_request(FUNC_ALLOC, 15'h7FFF);
    send_request(FUNC_MARK_USED, 15'd0);
    send_request(FUNC_FREE, 15'd0);
    send_request(FUNC_FREE, 15'd31);
    send_request(FUNC_FREE, 15'd32);
    send_request(FUNC_FREE, 15'h7FFF);
    send_request(FUNC_FREE, 15'h7FFF);
    send_request(FUNC_NOP, 15'h7FFF);
    send_request(FUNC_NOP, 15'd0);
    send_request(FUNC_ALLOC, 15'h5555);
    send_request(FUNC_ALLOC, 15'h2AAA);
    send_request(FUNC_ALLOC, 15'd0);
    send_request(FUNC_FREE, 15'd100);
    send_request(FUNC_MARK_USED, 15'd100);
    send_request(FUNC_ALLOC, 15'd0);
    send_request(FUNC_ALLOC, 15'h7FFF);
    send_request(FUNC_FREE, 15'h2AAA);
    send_request(FUNC_FREE, 15'h1555);
    send_request(FUNC_ALLOC, 15'd0);
    send_request(FUNC_MARK_USED, 15'h2AAA);
    send_request(FUNC_ALLOC, 15'd0);
    send_request(FUNC_FREE, 15'd7);
    send_request(FUNC_FREE, 15'd3);
    send_request(FUNC_ALLOC, 15'd0);

    // random phases: fill, mixed and drain, mostly in a low window of pages
    for (ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0:       kind = PH_FILL;
        2:       kind = PH_DRAIN;
        default: kind = PH_MIXED;
      endcase
      quiet = (ph % 4 == 3);
      case ($urandom_range(0, 3))
        0:       win = 32;
        1:       win = 256;
        2:       win = 1024;
        default: win = 4096;
      endcase
      case (kind)
        PH_FILL: begin
          alloc_th = 20; free_th = 90; mark_th = 95;
        end
        PH_DRAIN: begin
          alloc_th = 60; free_th = 90; mark_th = 95;
        end
        default: begin
          alloc_th = 35; free_th = 75; mark_th = 92;
        end
      endcase
      repeat (250) begin
        roll = $urandom_range(0, 99);
        if (roll < alloc_th)     f = FUNC_ALLOC;
        else if (roll < free_th) f = FUNC_FREE;
        else if (roll < mark_th) f = FUNC_MARK_USED;
        else                     f = FUNC_NOP;
        if ($urandom_range(0, 99) < 85) p = PAGE_W'($urandom_range(0, win - 1));
        else                            p = PAGE_W'($urandom_range(0, PAGE_COUNT - 1));
        send_request(f, p);
      end
    end
    in_valid <= 1'b0;

    // let the monitor note the last request beat before counting grants
    @(posedge clk);

    // drain outstanding grants, then watch for strays
    while (tracker.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/pba_pkg.sv
rtl/pba_bit_find.sv
rtl/page_bitmap_allocator_core.sv
tb/tb_top.sv
